FILE: rtl/ttyld_pkg.sv
// Shared types and constants for the terminal line discipline.
// Holds line buffer sizing, result channel codes, register indexes and
// the structures passed between the sequencer, config and output stages.
package ttyld_pkg;

    // Line buffer sizing
    localparam int LINE_DEPTH  = 32;
    localparam int ADDR_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LINE_DEPTH + 1);

    // Cap on results produced by one received byte
    localparam int MAX_RESULTS = 34;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // Echo script held per byte (erase of a control byte is the longest)
    localparam int SCRIPT_LEN  = 6;
    localparam int SCR_W       = $clog2(SCRIPT_LEN + 1);

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGCHARS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDITCHARS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENDCHARS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FGGROUP  = 3'd6;

    // Result channels
    localparam logic [1:0] CH_ECHO    = 2'd0;
    localparam logic [1:0] CH_DELIVER = 2'd1;
    localparam logic [1:0] CH_SIGNAL  = 2'd2;

    // Signal codes
    localparam logic [1:0] SIG_INT  = 2'd0;
    localparam logic [1:0] SIG_QUIT = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    typedef struct packed {
        logic [3:0]  iflag;
        logic [2:0]  oflag;
        logic [6:0]  lflag;
        logic [23:0] sigc;
        logic [23:0] editc;
        logic [15:0] endc;
        logic [15:0] fg;
    } t_cfg;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] data;
        logic [1:0] sig;
    } t_res;

    typedef struct packed {
        logic push;
        logic fin;
        t_res res;
    } t_emit;

endpackage

FILE: rtl/tty_line_discipline.sv
// Top level of the terminal line discipline.
// Depends on ttyld_pkg, ttyld_cfg, ttyld_line_ram, ttyld_ctrl and ttyld_out.
//
//  Group      Dir  Payload
//  s_axis     in   tdata[7:0] rx_byte
//  m_axis     out  tuser[1:0] channel; tdata[7:0] data_byte, [9:8] signal_code;
//                  tlast last
//  i_cfg_*    in   register index, write data, write enable
//
// A byte passes from idle through decode and its echo script, then a single
// tail result or a line release, then finish; a line release is paced by the
// single read port of the line buffer RAM streaming one byte per cycle while
// the result staging has room, and waiting whenever it has none.
// Synchronous reset clears the line count and literal-next state; the line
// RAM is not cleared. m_axis_tready low freezes the sequencer behind a hold
// stage and the output register; the next byte is taken once the last
// result of the previous one is staged.
module tty_line_discipline
    import ttyld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [7:0] data_byte, [9:8] signal_code
    output logic [1:0]            m_axis_tuser,   // [1:0] channel
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_emit             emit;
    t_res              res;
    logic              space;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // Configuration registers
    ttyld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Line buffer
    ttyld_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Byte sequencer
    ttyld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .o_emit      (emit),
        .i_space     (space),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Result staging
    ttyld_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res),
        .o_last  (m_axis_tlast)
    );

    // Pack the result transaction
    assign m_axis_tdata = {6'b000000, res.sig, res.data};
    assign m_axis_tuser = res.channel;

endmodule

FILE: rtl/ttyld_line_ram.sv
// Line buffer storage: one write port, one registered read port.
// Depends on ttyld_pkg for depth and address width.
module ttyld_line_ram
    import ttyld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [LINE_DEPTH];
    logic [7:0] r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ttyld_cfg.sv
// Configuration register file written through a plain write port.
// Depends on ttyld_pkg for register indexes and the t_cfg structure.
module ttyld_cfg
    import ttyld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    localparam logic [3:0]  RST_IFLAG = 4'd8;
    localparam logic [2:0]  RST_OFLAG = 3'd1;
    localparam logic [6:0]  RST_LFLAG = 7'd119;
    localparam logic [23:0] RST_SIGC  = 24'h1A1C03;
    localparam logic [23:0] RST_EDITC = 24'h16157F;
    localparam logic [15:0] RST_ENDC  = 16'h0004;
    localparam logic [15:0] RST_FG    = 16'h0000;

    logic [3:0]  r_iflag;
    logic [2:0]  r_oflag;
    logic [6:0]  r_lflag;
    logic [23:0] r_sigc;
    logic [23:0] r_editc;
    logic [15:0] r_endc;
    logic [15:0] r_fg;

    // Load the addressed register; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iflag <= RST_IFLAG;
            r_oflag <= RST_OFLAG;
            r_lflag <= RST_LFLAG;
            r_sigc  <= RST_SIGC;
            r_editc <= RST_EDITC;
            r_endc  <= RST_ENDC;
            r_fg    <= RST_FG;
        end else if (i_we) begin
            case (i_idx)
                REG_INPUT:     r_iflag <= i_data[3:0];
                REG_OUTPUT:    r_oflag <= i_data[2:0];
                REG_LOCAL:     r_lflag <= i_data[6:0];
                REG_SIGCHARS:  r_sigc  <= i_data[23:0];
                REG_EDITCHARS: r_editc <= i_data[23:0];
                REG_ENDCHARS:  r_endc  <= i_data[15:0];
                REG_FGGROUP:   r_fg    <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.iflag = r_iflag;
    assign o_cfg.oflag = r_oflag;
    assign o_cfg.lflag = r_lflag;
    assign o_cfg.sigc  = r_sigc;
    assign o_cfg.editc = r_editc;
    assign o_cfg.endc  = r_endc;
    assign o_cfg.fg    = r_fg;

endmodule

FILE: rtl/ttyld_out.sv
// Result staging: a hold register one result behind and the output register.
// The hold stage lets the final result of a byte be marked once the byte ends.
// Depends on ttyld_pkg for t_res and t_emit.
module ttyld_out
    import ttyld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_emit i_emit,
    output logic  o_space,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_res,
    output logic  o_last
);

    logic r_hold_v, n_hold_v;
    t_res r_hold,   n_hold;
    logic r_out_v,  n_out_v;
    t_res r_out,    n_out;
    logic r_out_last, n_out_last;
    logic out_free;

    assign out_free = !r_out_v || i_ready;
    assign o_space  = !r_hold_v || out_free;

    // Advance results: new one into hold, previous one out with last clear;
    // on finish, send the held result out marked last
    always_comb begin
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_out_v    = r_out_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end
        if (i_emit.push && o_space) begin
            if (r_hold_v) begin
                n_out      = r_hold;
                n_out_last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_hold   = i_emit.res;
            n_hold_v = 1'b1;
        end else if (i_emit.fin && o_space && r_hold_v) begin
            n_out      = r_hold;
            n_out_last = 1'b1;
            n_out_v    = 1'b1;
            n_hold_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/ttyld_ctrl.sv
// Byte sequencer: decodes one received byte against the line state,
// reads and writes the line buffer RAM and streams echo and delivery results.
// Depends on ttyld_pkg; drives ttyld_line_ram and ttyld_out.
module ttyld_ctrl
    import ttyld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    output t_emit             o_emit,
    input  logic              i_space,
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output logic [7:0]        o_mem_wdata,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  logic [7:0]        i_mem_rdata
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_ECHO = 3'd2;
    localparam logic [2:0] S_ONE  = 3'd3;
    localparam logic [2:0] S_REL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // Work after the echo script
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_ONE  = 2'd1;
    localparam logic [1:0] TAIL_REL  = 2'd2;

    // Byte values
    localparam logic [7:0] B_NL    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_BS    = 8'h08;
    localparam logic [7:0] B_SP    = 8'h20;
    localparam logic [7:0] B_CARET = 8'h5E;
    localparam logic [7:0] B_AT    = 8'h40;
    localparam logic [7:0] B_DEL   = 8'h7F;
    localparam logic [7:0] B_LC_A  = 8'h61;
    localparam logic [7:0] B_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam logic [7:0] LOW7    = 8'h7F;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);
    localparam logic [RES_W-1:0] MAXR_C  = RES_W'(MAX_RESULTS);

    function automatic logic is_ctl(input logic [7:0] b);
        return (b < B_SP) || (b == B_DEL);
    endfunction

    function automatic logic [7:0] caret_of(input logic [7:0] b);
        logic [7:0] s;
        s = B_AT + b;
        return s & LOW7;
    endfunction

    // Flag decode
    logic f_istrip, f_igncr, f_inlcr, f_icrnl;
    logic f_onlcr, f_ocrdrop, f_olcuc;
    logic f_echo, f_echoe, f_echok, f_echonl, f_canon, f_isig, f_iext;
    logic [7:0] ch_erase, ch_kill, ch_lnext, ch_eof, ch_eol;

    assign f_istrip  = i_cfg.iflag[0];
    assign f_igncr   = i_cfg.iflag[1];
    assign f_inlcr   = i_cfg.iflag[2];
    assign f_icrnl   = i_cfg.iflag[3];
    assign f_onlcr   = i_cfg.oflag[0];
    assign f_ocrdrop = i_cfg.oflag[1];
    assign f_olcuc   = i_cfg.oflag[2];
    assign f_echo    = i_cfg.lflag[0];
    assign f_echoe   = i_cfg.lflag[1];
    assign f_echok   = i_cfg.lflag[2];
    assign f_echonl  = i_cfg.lflag[3];
    assign f_canon   = i_cfg.lflag[4];
    assign f_isig    = i_cfg.lflag[5];
    assign f_iext    = i_cfg.lflag[6];
    assign ch_erase  = i_cfg.editc[7:0];
    assign ch_kill   = i_cfg.editc[15:8];
    assign ch_lnext  = i_cfg.editc[23:16];
    assign ch_eof    = i_cfg.endc[7:0];
    assign ch_eol    = i_cfg.endc[15:8];

    // Registers
    logic [2:0]                  r_state, n_state;
    logic [7:0]                  r_byte,  n_byte;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_vpend, n_vpend;
    logic [SCRIPT_LEN-1:0][7:0]  r_ech,   n_ech;
    logic [SCR_W-1:0]            r_ech_n, n_ech_n;
    logic                        r_half,  n_half;
    logic [1:0]                  r_tail,  n_tail;
    t_res                        r_tail_res, n_tail_res;
    logic [CNT_W-1:0]            r_rel_n, n_rel_n;
    logic [CNT_W-1:0]            r_idx,   n_idx;
    logic [RES_W-1:0]            r_res_n, n_res_n;

    // Decode results
    logic [7:0]                  c1, c2;
    logic                        sig_hit;
    logic [1:0]                  sig_k;
    logic                        full;
    logic [CNT_W-1:0]            p_count;
    logic [SCRIPT_LEN-1:0][7:0]  d_ech;
    logic [SCR_W-1:0]            d_ech_n;
    logic [1:0]                  d_tail;
    t_res                        d_tail_res;
    logic [CNT_W-1:0]            d_rel_n;
    logic [CNT_W-1:0]            d_count;
    logic                        d_vpend;
    logic                        d_we;
    logic [7:0]                  d_wdata;

    // Echo and release step signals
    logic                        want;
    t_res                        want_res;
    logic [7:0]                  eb;
    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            rel_last;
    logic [CNT_W-1:0]            idx_p1;

    assign full     = r_count >= DEPTH_C;
    assign p_count  = full ? r_count : r_count + CNT_W'(1);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign rel_last = r_rel_n - CNT_W'(1);
    assign idx_p1   = r_idx + CNT_W'(1);

    // Match signal bytes on the raw byte, interrupt first
    always_comb begin
        sig_hit = 1'b1;
        sig_k   = SIG_INT;
        if (r_byte == i_cfg.sigc[7:0]) begin
            sig_k = SIG_INT;
        end else if (r_byte == i_cfg.sigc[15:8]) begin
            sig_k = SIG_QUIT;
        end else if (r_byte == i_cfg.sigc[23:16]) begin
            sig_k = SIG_SUSP;
        end else begin
            sig_hit = 1'b0;
        end
    end

    // Input mapping
    always_comb begin
        c1 = f_istrip ? (r_byte & LOW7) : r_byte;
        if (f_inlcr && c1 == B_NL) begin
            c2 = B_CR;
        end else if (f_icrnl && c1 == B_CR) begin
            c2 = B_NL;
        end else begin
            c2 = c1;
        end
    end

    // Decode the byte into line edits, an echo script and a tail action
    always_comb begin
        d_ech      = '0;
        d_ech_n    = '0;
        d_tail     = TAIL_NONE;
        d_tail_res = '0;
        d_rel_n    = '0;
        d_count    = r_count;
        d_vpend    = 1'b0;
        d_we       = 1'b0;
        d_wdata    = c2;
        if (r_vpend) begin
            // store the byte as it came
            d_wdata = r_byte;
            if (!full) begin
                d_we    = 1'b1;
                d_count = p_count;
                if (f_echo) begin
                    if (is_ctl(r_byte)) begin
                        d_ech[0] = B_CARET;
                        d_ech[1] = caret_of(r_byte);
                        d_ech_n  = SCR_W'(2);
                    end else begin
                        d_ech[0] = r_byte;
                        d_ech_n  = SCR_W'(1);
                    end
                end
            end
        end else if (f_isig && sig_hit) begin
            if (f_echo) begin
                d_ech[0] = B_CARET;
                d_ech[1] = caret_of(r_byte);
                d_ech[2] = B_NL;
                d_ech_n  = SCR_W'(3);
            end
            d_count = '0;
            if (i_cfg.fg != 16'h0000) begin
                d_tail             = TAIL_ONE;
                d_tail_res.channel = CH_SIGNAL;
                d_tail_res.sig     = sig_k;
            end
        end else if (f_igncr && c1 == B_CR) begin
            // drop the carriage return
        end else if (!f_canon) begin
            if (f_echo) begin
                d_ech[0] = c2;
                d_ech_n  = SCR_W'(1);
            end
            d_tail             = TAIL_ONE;
            d_tail_res.channel = CH_DELIVER;
            d_tail_res.data    = c2;
        end else if (f_iext && c2 == ch_lnext) begin
            d_vpend = 1'b1;
            if (f_echo) begin
                d_ech[0] = B_CARET;
                d_ech[1] = B_BS;
                d_ech_n  = SCR_W'(2);
            end
        end else if (c2 == ch_kill) begin
            d_count = '0;
            if (f_echo && !f_echok) begin
                d_ech[0] = B_CARET;
                d_ech[1] = caret_of(c2);
                d_ech_n  = SCR_W'(2);
            end
        end else if (c2 == ch_erase) begin
            if (r_count != '0) begin
                d_count = cnt_m1;
                if (f_echo && f_echoe) begin
                    d_ech[0] = B_BS;
                    d_ech[1] = B_SP;
                    d_ech[2] = B_BS;
                    d_ech[3] = B_BS;
                    d_ech[4] = B_SP;
                    d_ech[5] = B_BS;
                    d_ech_n  = is_ctl(i_mem_rdata) ? SCR_W'(6) : SCR_W'(3);
                end
            end
            if (f_echo && !f_echoe) begin
                d_ech[0] = B_CARET;
                d_ech[1] = caret_of(c2);
                d_ech_n  = SCR_W'(2);
            end
        end else if (ch_eof != 8'h00 && c2 == ch_eof) begin
            if (r_count != '0) begin
                d_tail  = TAIL_REL;
                d_rel_n = r_count;
                d_count = '0;
            end
        end else begin
            if (!full) begin
                d_we    = 1'b1;
                d_count = p_count;
                if (f_echo) begin
                    if (is_ctl(c2) && c2 != B_NL) begin
                        d_ech[0] = B_CARET;
                        d_ech[1] = caret_of(c2);
                        d_ech_n  = SCR_W'(2);
                    end else begin
                        d_ech[0] = c2;
                        d_ech_n  = SCR_W'(1);
                    end
                end
            end
            if (c2 == B_NL || (ch_eol != 8'h00 && c2 == ch_eol)) begin
                if (!f_echo && f_echonl) begin
                    d_ech[0] = c2;
                    d_ech_n  = SCR_W'(1);
                end
                d_tail  = TAIL_REL;
                d_rel_n = p_count;
                d_count = '0;
            end
        end
    end

    // Sequence the byte: decode, echo script, tail, finish
    always_comb begin
        n_state    = r_state;
        n_byte     = r_byte;
        n_count    = r_count;
        n_vpend    = r_vpend;
        n_ech      = r_ech;
        n_ech_n    = r_ech_n;
        n_half     = r_half;
        n_tail     = r_tail;
        n_tail_res = r_tail_res;
        n_rel_n    = r_rel_n;
        n_idx      = r_idx;
        n_res_n    = r_res_n;
        want       = 1'b0;
        want_res   = '0;
        o_emit.fin = 1'b0;
        eb         = r_ech[0];
        o_mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                // point the read port at the last stored byte for erase
                o_mem_raddr = (r_count == '0) ? '0 : cnt_m1[ADDR_W-1:0];
                if (i_in_valid) begin
                    n_byte  = i_in_byte;
                    n_res_n = '0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_count    = d_count;
                n_vpend    = d_vpend;
                n_ech      = d_ech;
                n_ech_n    = d_ech_n;
                n_half     = 1'b0;
                n_tail     = d_tail;
                n_tail_res = d_tail_res;
                n_rel_n    = d_rel_n;
                n_idx      = '0;
                n_state    = S_ECHO;
            end
            S_ECHO: begin
                want_res.channel = CH_ECHO;
                if (r_ech_n == '0) begin
                    if (r_tail == TAIL_ONE) begin
                        n_state = S_ONE;
                    end else if (r_tail == TAIL_REL && r_rel_n != '0) begin
                        n_state = S_REL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (eb == B_NL && f_onlcr) begin
                    // newline goes out as CR then NL
                    if (i_space) begin
                        want          = 1'b1;
                        want_res.data = r_half ? B_NL : B_CR;
                        n_half        = !r_half;
                        if (r_half) begin
                            n_ech   = {8'h00, r_ech[SCRIPT_LEN-1:1]};
                            n_ech_n = r_ech_n - SCR_W'(1);
                        end
                    end
                end else if (eb == B_CR && f_ocrdrop) begin
                    n_ech   = {8'h00, r_ech[SCRIPT_LEN-1:1]};
                    n_ech_n = r_ech_n - SCR_W'(1);
                end else if (i_space) begin
                    want          = 1'b1;
                    want_res.data = (f_olcuc && eb >= B_LC_A && eb <= B_LC_Z) ?
                                    eb - CASE_GAP : eb;
                    n_ech         = {8'h00, r_ech[SCRIPT_LEN-1:1]};
                    n_ech_n       = r_ech_n - SCR_W'(1);
                end
            end
            S_ONE: begin
                if (i_space) begin
                    want     = 1'b1;
                    want_res = r_tail_res;
                    n_state  = S_FIN;
                end
            end
            S_REL: begin
                // stream the line, one stored byte per cycle while the output has room
                want_res.channel = CH_DELIVER;
                want_res.data    = i_mem_rdata;
                o_mem_raddr      = i_space ? idx_p1[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
                if (i_space) begin
                    want = 1'b1;
                    if (r_idx == rel_last) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = idx_p1;
                    end
                end
            end
            S_FIN: begin
                o_emit.fin = 1'b1;
                if (i_space) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // drop results beyond the cap
        o_emit.push = want && (r_res_n < MAXR_C);
        o_emit.res  = want_res;
        if (o_emit.push) begin
            n_res_n = r_res_n + RES_W'(1);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_mem_we    = (r_state == S_DEC) && d_we;
    assign o_mem_waddr = r_count[ADDR_W-1:0];
    assign o_mem_wdata = d_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_vpend <= 1'b0;
            r_ech_n <= '0;
            r_half  <= 1'b0;
            r_res_n <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_vpend <= n_vpend;
            r_ech_n <= n_ech_n;
            r_half  <= n_half;
            r_res_n <= n_res_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_ech      <= n_ech;
        r_tail     <= n_tail;
        r_tail_res <= n_tail_res;
        r_rel_n    <= n_rel_n;
        r_idx      <= n_idx;
    end

    // Checks on line state and result flow
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("line count beyond buffer depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_count < DEPTH_C))
        else $error("line buffer written while full");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.push |-> i_space)
        else $error("result pushed without room");

    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DEC))
        else $error("accepted byte not decoded next cycle");

    a_rel_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL) |-> (r_idx < r_rel_n))
        else $error("release index past line end");

endmodule

FILE: bench/ttyld_checker.sv
// Result checker for the terminal line discipline bench.
// Watches the received-byte, result and register-write ports, predicts the
// results of every received byte and compares them in order. Uses ttyld_pkg.
module ttyld_checker
    import ttyld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [15:0]           m_axis_tdata,   // [7:0] data_byte, [9:8] signal_code
    input  logic [1:0]            m_axis_tuser,   // [1:0] channel
    input  logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    // Character codes
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_AT    = 8'h40;
    localparam logic [7:0] CHR_CARET = 8'h5E;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_Z = 8'h7A;
    localparam logic [7:0] CHR_DEL   = 8'h7F;

    // Flag bit positions
    localparam int IF_STRIP   = 0;
    localparam int IF_IGNCR   = 1;
    localparam int IF_NLCR    = 2;
    localparam int IF_CRNL    = 3;
    localparam int OF_NL_CRNL = 0;
    localparam int OF_DROP_CR = 1;
    localparam int OF_UPCASE  = 2;
    localparam int LF_ECHO    = 0;
    localparam int LF_ECHOE   = 1;
    localparam int LF_ECHOK   = 2;
    localparam int LF_ECHONL  = 3;
    localparam int LF_CANON   = 4;
    localparam int LF_ISIG    = 5;
    localparam int LF_EXTEN   = 6;

    localparam logic [1:0] SIG_NONE = 2'd0;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] data;
        logic [1:0] sig;
        logic       last;
    } t_exp_res;

    t_cfg        regs;
    logic [7:0]  line_mem [LINE_DEPTH];
    int          line_len;
    logic        lnext_armed;
    t_exp_res    owed_results [$];
    t_exp_res    byte_results [$];
    t_exp_res    tail_res;
    t_exp_res    got_res;
    t_exp_res    want_res;
    int          errors = 0;

    function automatic string fmt_res(input t_exp_res r);
        return $sformatf("ch=%0d data=%02h sig=%0d last=%0b",
                         r.channel, r.data, r.sig, r.last);
    endfunction

    function automatic void add_result(input logic [1:0] ch, input logic [7:0] d,
                                       input logic [1:0] s);
        t_exp_res r;
        if (byte_results.size() >= MAX_RESULTS) return;
        r.channel = ch;
        r.data    = d;
        r.sig     = s;
        r.last    = 1'b0;
        byte_results.push_back(r);
    endfunction

    // Echo through the output mapping
    function automatic void add_echo(input logic [7:0] c);
        logic [7:0] shown;
        shown = c;
        if (c == CHR_NL && regs.oflag[OF_NL_CRNL]) begin
            add_result(CH_ECHO, CHR_CR, SIG_NONE);
            add_result(CH_ECHO, CHR_NL, SIG_NONE);
            return;
        end
        if (c == CHR_CR && regs.oflag[OF_DROP_CR]) return;
        if (c >= CHR_LOW_A && c <= CHR_LOW_Z && regs.oflag[OF_UPCASE]) shown = c - 8'd32;
        add_result(CH_ECHO, shown, SIG_NONE);
    endfunction

    function automatic logic is_ctl_chr(input logic [7:0] c);
        return (c < CHR_SP) || (c == CHR_DEL);
    endfunction

    // Caret pair, second byte folded into seven bits
    function automatic void add_caret(input logic [7:0] c);
        logic [7:0] shifted;
        shifted    = CHR_AT + c;
        shifted[7] = 1'b0;
        add_echo(CHR_CARET);
        add_echo(shifted);
    endfunction

    function automatic logic store_byte(input logic [7:0] c);
        if (line_len >= LINE_DEPTH) return 1'b0;
        line_mem[line_len] = c;
        line_len++;
        return 1'b1;
    endfunction

    function automatic void release_line();
        for (int i = 0; i < line_len; i++) add_result(CH_DELIVER, line_mem[i], SIG_NONE);
        line_len = 0;
    endfunction

    // Work out the results of one received byte
    function automatic void apply_rx_byte(input logic [7:0] rx);
        logic [7:0] c;
        logic [7:0] eof_chr;
        logic [7:0] eol_chr;
        logic [1:0] code;
        logic       echo_on;
        logic       echoe;
        int         reps;
        c       = rx;
        echo_on = regs.lflag[LF_ECHO];
        echoe   = regs.lflag[LF_ECHOE];
        eof_chr = regs.endc[7:0];
        eol_chr = regs.endc[15:8];

        // byte after literal-next goes in untouched
        if (lnext_armed) begin
            lnext_armed = 1'b0;
            if (store_byte(c) && echo_on) begin
                if (is_ctl_chr(c)) add_caret(c);
                else add_echo(c);
            end
            return;
        end

        if (regs.lflag[LF_ISIG]) begin
            for (int k = 0; k < 3; k++) begin
                if (c == regs.sigc[8*k +: 8]) begin
                    code = (k == 0) ? SIG_INT : (k == 1) ? SIG_QUIT : SIG_SUSP;
                    if (echo_on) begin
                        add_caret(c);
                        add_echo(CHR_NL);
                    end
                    line_len = 0;
                    if (regs.fg != 16'd0) add_result(CH_SIGNAL, 8'h00, code);
                    return;
                end
            end
        end

        // input mapping
        if (regs.iflag[IF_STRIP]) c[7] = 1'b0;
        if (regs.iflag[IF_IGNCR] && c == CHR_CR) return;
        if (regs.iflag[IF_NLCR] && c == CHR_NL) c = CHR_CR;
        else if (regs.iflag[IF_CRNL] && c == CHR_CR) c = CHR_NL;

        if (!regs.lflag[LF_CANON]) begin
            if (echo_on) add_echo(c);
            add_result(CH_DELIVER, c, SIG_NONE);
            return;
        end

        if (regs.lflag[LF_EXTEN] && c == regs.editc[23:16]) begin
            lnext_armed = 1'b1;
            if (echo_on) begin
                add_echo(CHR_CARET);
                add_echo(CHR_BS);
            end
            return;
        end

        if (c == regs.editc[15:8]) begin
            line_len = 0;
            if (echo_on && !regs.lflag[LF_ECHOK]) add_caret(c);
            return;
        end

        // erase: rub out twice for a control byte
        if (c == regs.editc[7:0]) begin
            if (line_len > 0) begin
                line_len--;
                reps = is_ctl_chr(line_mem[line_len]) ? 2 : 1;
                if (echo_on && echoe) begin
                    for (int k = 0; k < reps; k++) begin
                        add_echo(CHR_BS);
                        add_echo(CHR_SP);
                        add_echo(CHR_BS);
                    end
                end
            end
            if (echo_on && !echoe) add_caret(c);
            return;
        end

        if (eof_chr != 8'h00 && c == eof_chr) begin
            if (line_len > 0) release_line();
            return;
        end

        if (store_byte(c) && echo_on) begin
            if (is_ctl_chr(c) && c != CHR_NL) add_caret(c);
            else add_echo(c);
        end
        if (c == CHR_NL || (eol_chr != 8'h00 && c == eol_chr)) begin
            if (!echo_on && regs.lflag[LF_ECHONL]) add_echo(c);
            release_line();
        end
    endfunction

    // Compare results, then predict new bytes, then track register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.iflag  <= 4'h8;
            regs.oflag  <= 3'h1;
            regs.lflag  <= 7'h77;
            regs.sigc   <= 24'h1A1C03;
            regs.editc  <= 24'h16157F;
            regs.endc   <= 16'h0004;
            regs.fg     <= 16'h0000;
            line_len    = 0;
            lnext_armed = 1'b0;
            owed_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.channel = m_axis_tuser;
                got_res.data    = m_axis_tdata[7:0];
                got_res.sig     = m_axis_tdata[9:8];
                got_res.last    = m_axis_tlast;
                if (owed_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got %s",
                             $time, fmt_res(got_res));
                end else begin
                    want_res = owed_results.pop_front();
                    if (got_res !== want_res) begin
                        errors++;
                        $display("%0t: mismatch: expected %s, got %s",
                                 $time, fmt_res(want_res), fmt_res(got_res));
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                byte_results.delete();
                apply_rx_byte(s_axis_tdata);
                if (byte_results.size() > 0) begin
                    tail_res      = byte_results.pop_back();
                    tail_res.last = 1'b1;
                    byte_results.push_back(tail_res);
                end
                while (byte_results.size() > 0) owed_results.push_back(byte_results.pop_front());
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INPUT:     regs.iflag <= i_cfg_data[3:0];
                    REG_OUTPUT:    regs.oflag <= i_cfg_data[2:0];
                    REG_LOCAL:     regs.lflag <= i_cfg_data[6:0];
                    REG_SIGCHARS:  regs.sigc  <= i_cfg_data[23:0];
                    REG_EDITCHARS: regs.editc <= i_cfg_data[23:0];
                    REG_ENDCHARS:  regs.endc  <= i_cfg_data[15:0];
                    REG_FGGROUP:   regs.fg    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= owed_results.size();
    end

endmodule

FILE: bench/tb_tty_line_discipline.sv
// Testbench top for the terminal line discipline.
// Drives received bytes, register writes and result back-pressure; checking is
// done by ttyld_checker. Depends on ttyld_pkg and the tty_line_discipline RTL.
module tb_tty_line_discipline;
    import ttyld_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int errors;
    int pending;
    bit quiet       = 1'b0;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    // register values as last written, for choosing special bytes
    logic [CFG_DATA_W-1:0] reg_copy [7];

    logic [7:0] directed_bytes [23] = '{
        8'h68, 8'h69, 8'h01, 8'h7F, 8'h7F, 8'h16, 8'h03, 8'h16, 8'h78, 8'hFF,
        8'h80, 8'h0D, 8'h04, 8'h71, 8'h04, 8'h7A, 8'h15, 8'h03, 8'h1C, 8'h1A,
        8'h7F, 8'h00, 8'h0A
    };

    always #6 i_clk = ~i_clk;

    tty_line_discipline dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    ttyld_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // Result side: random stalls, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_tty_line_discipline: errors");
            $finish;
        end
    end

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(99) < 6) ? $urandom_range(4, 1) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every result and let a silent byte finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        reg_copy[idx] = val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_special();
        logic [7:0] b;
        case ($urandom_range(5))
            0:       b = reg_copy[REG_EDITCHARS][7:0];
            1:       b = reg_copy[REG_EDITCHARS][15:8];
            2:       b = reg_copy[REG_EDITCHARS][23:16];
            3:       b = reg_copy[REG_SIGCHARS][7:0];
            4:       b = reg_copy[REG_SIGCHARS][15:8];
            default: b = reg_copy[REG_SIGCHARS][23:16];
        endcase
        return b;
    endfunction

    // Line content: mostly text, some edits and signals, some noise
    function automatic logic [7:0] pick_body_byte();
        logic [7:0] b;
        int         r;
        r = $urandom_range(99);
        if (r < 55)      b = 8'($urandom_range(8'h7E, 8'h20));
        else if (r < 65) b = 8'($urandom_range(8'h7A, 8'h61));
        else if (r < 75) b = pick_special();
        else if (r < 85) b = 8'($urandom_range(8'h1F, 8'h00));
        else             b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] pick_line_end();
        logic [7:0] b;
        case ($urandom_range(4))
            0:       b = 8'h0A;
            1:       b = 8'h0D;
            2:       b = reg_copy[REG_ENDCHARS][7:0];
            3:       b = reg_copy[REG_ENDCHARS][15:8];
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // Random lines, short mostly, now and then long enough to fill the buffer
    task automatic run_lines(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 28) : $urandom_range(8);
            for (int i = 0; i < len && sent < budget; i++) begin
                send_byte(pick_body_byte());
                sent++;
            end
            if (sent < budget) begin
                send_byte(pick_line_end());
                sent++;
            end
        end
    endtask

    initial begin
        reg_copy[REG_INPUT]     = 24'h000008;
        reg_copy[REG_OUTPUT]    = 24'h000001;
        reg_copy[REG_LOCAL]     = 24'h000077;
        reg_copy[REG_SIGCHARS]  = 24'h1A1C03;
        reg_copy[REG_EDITCHARS] = 24'h16157F;
        reg_copy[REG_ENDCHARS]  = 24'h000004;
        reg_copy[REG_FGGROUP]   = 24'h000000;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edits, literal-next, EOF, kill and signals at reset settings with a live foreground group
        set_reg(REG_FGGROUP, 24'h000001);
        for (int i = 0; i < 23; i++) send_byte(directed_bytes[i]);
        settle();

        // reset settings with the foreground group still set, and a long hold on the result side
        holds_asked++;
        run_lines(40);
        settle();

        // every mapping and local flag on, CR as extra line end
        set_reg(REG_INPUT, 24'h00000F);
        set_reg(REG_OUTPUT, 24'h000007);
        set_reg(REG_LOCAL, 24'h00007F);
        set_reg(REG_ENDCHARS, 24'h000D04);
        run_lines(40);
        settle();

        // all ones
        set_reg(REG_SIGCHARS, 24'hFFFFFF);
        set_reg(REG_EDITCHARS, 24'hFFFFFF);
        set_reg(REG_ENDCHARS, 24'h00FFFF);
        set_reg(REG_FGGROUP, 24'h00FFFF);
        run_lines(30);
        settle();

        // all zeros: raw, silent, and no idling on either side
        set_reg(REG_INPUT, 24'h000000);
        set_reg(REG_OUTPUT, 24'h000000);
        set_reg(REG_LOCAL, 24'h000000);
        set_reg(REG_SIGCHARS, 24'h000000);
        set_reg(REG_EDITCHARS, 24'h000000);
        set_reg(REG_ENDCHARS, 24'h000000);
        set_reg(REG_FGGROUP, 24'h000000);
        quiet = 1'b1;
        run_lines(30);
        settle();
        quiet = 1'b0;

        // raw with echo and upper-case output
        set_reg(REG_LOCAL, 24'h000001);
        set_reg(REG_OUTPUT, 24'h000005);
        set_reg(REG_INPUT, 24'h000008);
        run_lines(30);
        settle();

        // canonical, plain erase echo, no literal-next, ';' ends a line
        set_reg(REG_LOCAL, 24'h000031);
        set_reg(REG_SIGCHARS, 24'h1A1C03);
        set_reg(REG_EDITCHARS, 24'h16157F);
        set_reg(REG_ENDCHARS, 24'h003B04);
        set_reg(REG_INPUT, 24'h000009);
        set_reg(REG_OUTPUT, 24'h000002);
        run_lines(40);
        settle();

        // echo off with line-end echo, EOF disabled
        set_reg(REG_LOCAL, 24'h000078);
        set_reg(REG_FGGROUP, 24'h008000);
        set_reg(REG_ENDCHARS, 24'h000D00);
        run_lines(40);
        settle();

        // echok without echoe, NL mapped to CR
        set_reg(REG_LOCAL, 24'h000075);
        set_reg(REG_INPUT, 24'h000004);
        set_reg(REG_ENDCHARS, 24'h000D04);
        set_reg(REG_OUTPUT, 24'h000001);
        run_lines(40);
        settle();

        // back to reset settings with a live foreground group
        set_reg(REG_INPUT, 24'h000008);
        set_reg(REG_OUTPUT, 24'h000001);
        set_reg(REG_LOCAL, 24'h000077);
        set_reg(REG_ENDCHARS, 24'h000004);
        set_reg(REG_FGGROUP, 24'h000001);
        run_lines(60);
        settle();

        if (errors == 0) begin
            $display("tb_tty_line_discipline: clean");
        end else begin
            $display("tb_tty_line_discipline: errors");
        end
        $finish;
    end

endmodule

FILE: tty_line_discipline.f
rtl/ttyld_pkg.sv
rtl/ttyld_line_ram.sv
rtl/ttyld_cfg.sv
rtl/ttyld_out.sv
rtl/ttyld_ctrl.sv
rtl/tty_line_discipline.sv
bench/ttyld_checker.sv
bench/tb_tty_line_discipline.sv
